### src/sxd_pkg.sv
// Shared constants, types and helper functions for the sixel stream decoder.
package sxd_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int CANVAS_LIMIT    = 4096;
  // Parameter slots any command actually reads back (palette set reads four + the live one).
  localparam int KEPT_SLOTS      = 4;
  localparam int NUM_DEFAULTS    = 16;

  // Result kinds
  localparam logic [1:0] KIND_RUN    = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_BAD    = 2'd3;

  // Raw stream bytes
  localparam logic [7:0] CH_DCS  = 8'h90;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_Q    = 8'h71;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Seven-bit body codes
  localparam logic [6:0] B_BANG   = 7'h21;
  localparam logic [6:0] B_QUOTE  = 7'h22;
  localparam logic [6:0] B_HASH   = 7'h23;
  localparam logic [6:0] B_DOLLAR = 7'h24;
  localparam logic [6:0] B_MINUS  = 7'h2D;
  localparam logic [6:0] B_CAN    = 7'h18;
  localparam logic [6:0] B_SUB    = 7'h1A;
  localparam logic [6:0] B_ESC    = 7'h1B;
  localparam logic [6:0] B_FS     = 7'h1C;
  localparam logic [6:0] B_SIXEL_FIRST = 7'h3F;
  localparam logic [6:0] B_SIXEL_LAST  = 7'h7E;

  // x/100 == (x * 5243) >> 19 exactly for x below 25600
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [23:0] DEFAULT_COLORS [NUM_DEFAULTS] = '{
    24'h000000, 24'h000080, 24'h800000, 24'h008000,
    24'h8000FF, 24'h008080, 24'hFFFF00, 24'hFFFFFF,
    24'h808080, 24'h0000FF, 24'hFF0000, 24'h00FF00,
    24'hFF00FF, 24'h00FFFF, 24'hFFFFC0, 24'hFFFFFF
  };

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [15:0]       pct_red;
    logic [15:0]       pct_green;
    logic [15:0]       pct_blue;
  } sxd_pal_wr_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [11:0] run_x;
    logic [11:0] band_y;
    logic [11:0] run_length;
    logic [5:0]  sixel_bits;
    logic [7:0]  ink_red;
    logic [7:0]  ink_green;
    logic [7:0]  ink_blue;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        opaque_background;
  } sxd_result_t;

  // Percentage (saturated at 100) to 0..255, rounding up
  function automatic logic [7:0] pct_to_byte(input logic [15:0] pct);
    logic [6:0]  p;
    logic [14:0] v;
    logic [27:0] prod;
    p    = (pct > 16'd100) ? 7'd100 : pct[6:0];
    v    = 15'(p) * 15'd255 + 15'd99;
    prod = 28'(v) * 28'(RECIP_100);
    return prod[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

endpackage

### src/sxd_in_if.sv
// Input byte channel: valid/ready with one stream byte or end-of-stream mark.
interface sxd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

### src/sxd_out_if.sv
// Result channel: valid/ready with one decoded result.
interface sxd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [11:0] run_x;
  logic [11:0] band_y;
  logic [11:0] run_length;
  logic [5:0]  sixel_bits;
  logic [7:0]  ink_red;
  logic [7:0]  ink_green;
  logic [7:0]  ink_blue;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic        opaque_background;

  modport source (output valid, output result_kind, output run_x, output band_y,
                  output run_length, output sixel_bits, output ink_red, output ink_green,
                  output ink_blue, output image_width, output image_height,
                  output opaque_background, input ready);
  modport sink   (input valid, input result_kind, input run_x, input band_y,
                  input run_length, input sixel_bits, input ink_red, input ink_green,
                  input ink_blue, input image_width, input image_height,
                  input opaque_background, output ready);
endinterface

### src/sxd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sxd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/sxd_palette.sv
// Color palette: RAM plus per-entry valid bits, default colors and write forwarding.
module sxd_palette import sxd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sxd_pal_wr_t       wr,
  input  logic [PAL_AW-1:0] rd_addr,
  output logic [23:0]       rd_data
);

  logic [23:0]                wr_data;
  logic [23:0]                ram_q;
  logic [PALETTE_ENTRIES-1:0] vld_r;
  logic                       vld_q_r;
  logic [23:0]                def_q_r;
  logic                       fwd_q_r;
  logic [23:0]                wdata_q_r;
  logic [23:0]                def_color;

  assign wr_data = {pct_to_byte(wr.pct_red), pct_to_byte(wr.pct_green),
                    pct_to_byte(wr.pct_blue)};

  assign def_color = (32'(rd_addr) < NUM_DEFAULTS) ? DEFAULT_COLORS[rd_addr[3:0]] : 24'd0;

  sxd_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Read side registers, aligned with the RAM output
  always_ff @(posedge clk) begin
    vld_q_r   <= vld_r[rd_addr];
    def_q_r   <= def_color;
    fwd_q_r   <= wr.en && (wr.addr == rd_addr);
    wdata_q_r <= wr_data;
  end

  assign rd_data = fwd_q_r ? wdata_q_r : (vld_q_r ? ram_q : def_q_r);

endmodule

### src/sxd_core.sv
// Byte parser: header search, parameter lists, body commands and run generation.
module sxd_core import sxd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [7:0]        data_byte,
  input  logic              end_of_stream,
  output logic [PAL_AW-1:0] pal_rd_addr,
  input  logic [23:0]       pal_rd_data,
  output sxd_pal_wr_t       pal_wr,
  output logic              res_vld,
  output sxd_result_t       res
);

  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_PARAMS = 2'd1;
  localparam logic [1:0] MODE_BODY   = 2'd2;
  localparam logic [1:0] MODE_DONE   = 2'd3;

  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_HEADER  = 3'd1;
  localparam logic [2:0] CMD_REPEAT  = 3'd2;
  localparam logic [2:0] CMD_RASTER  = 3'd3;
  localparam logic [2:0] CMD_PALETTE = 3'd4;

  localparam logic [12:0] REP_MAX = 13'd8191;

  logic [1:0]  mode_r, mode_nxt;
  logic        esc_r, esc_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [3:0]  pcnt_r, pcnt_nxt;
  logic [15:0] pv_r [KEPT_SLOTS];
  logic [15:0] pv_nxt [KEPT_SLOTS];
  logic [23:0] ink_r, ink_nxt;
  logic [11:0] col_r, col_nxt;
  logic [11:0] row_r, row_nxt;
  logic [12:0] wid_r, wid_nxt;
  logic [12:0] hgt_r, hgt_nxt;
  logic [12:0] rep_r, rep_nxt;
  logic        opq_r, opq_nxt;

  logic [6:0]  c;
  logic        is_digit;
  logic        is_semi;
  logic [19:0] acc_mul;
  logic [15:0] acc_dig;
  logic [15:0] p1;
  logic [15:0] p2;
  logic [15:0] rep_inc;
  logic [16:0] rep_sum;
  logic [12:0] rep_sat;
  logic        pal_in_range;
  logic [12:0] row_plus6;
  logic [12:0] rep_len;
  logic [13:0] col_len;
  logic        do_body;
  logic [1:0]  res_kind;
  logic [11:0] res_x;
  logic [11:0] res_y;
  logic [11:0] res_len;
  logic [5:0]  res_bits;

  assign c        = data_byte[6:0];
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign is_semi  = (data_byte == CH_SEMI);

  assign acc_mul = {acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + 20'(data_byte - CH_ZERO);
  assign acc_dig = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];

  // Values of the first two parameters as they stand once the live one is pushed
  assign p1 = (pcnt_r == 4'd0) ? acc_r : pv_r[0];
  assign p2 = (pcnt_r == 4'd1) ? acc_r : pv_r[1];

  assign rep_inc = (p1 == 16'd0) ? 16'd1 : p1;
  assign rep_sum = 17'(rep_r) + 17'(rep_inc);
  assign rep_sat = (rep_sum > 17'(REP_MAX)) ? REP_MAX : rep_sum[12:0];

  assign pal_in_range = 32'(acc_r) < PALETTE_ENTRIES;
  assign row_plus6    = 13'(row_r) + 13'd6;

  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    cmd_nxt  = cmd_r;
    acc_nxt  = acc_r;
    pcnt_nxt = pcnt_r;
    pv_nxt   = pv_r;
    ink_nxt  = ink_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    wid_nxt  = wid_r;
    hgt_nxt  = hgt_r;
    rep_nxt  = rep_r;
    opq_nxt  = opq_r;
    do_body  = 1'b0;
    res_vld  = 1'b0;
    res_kind = KIND_RUN;
    res_x    = '0;
    res_y    = '0;
    res_len  = '0;
    res_bits = '0;
    rep_len  = '0;
    col_len  = '0;
    pal_wr.en        = 1'b0;
    pal_wr.addr      = pv_r[0][PAL_AW-1:0];
    pal_wr.pct_red   = pv_r[2];
    pal_wr.pct_green = pv_r[3];
    pal_wr.pct_blue  = acc_r;

    if (in_accept) begin
      case (mode_r)
        MODE_SEARCH: begin
          if (end_of_stream) begin
            mode_nxt = MODE_DONE;
            res_vld  = 1'b1;
            res_kind = KIND_END;
          end else if (esc_r) begin
            esc_nxt = 1'b0;
            if (data_byte == CH_P) begin
              mode_nxt = MODE_PARAMS;
              cmd_nxt  = CMD_HEADER;
              acc_nxt  = '0;
              pcnt_nxt = '0;
            end
          end else if (data_byte == CH_DCS) begin
            mode_nxt = MODE_PARAMS;
            cmd_nxt  = CMD_HEADER;
            acc_nxt  = '0;
            pcnt_nxt = '0;
          end else if (data_byte == CH_ESC) begin
            esc_nxt = 1'b1;
          end
        end

        MODE_PARAMS: begin
          if (!end_of_stream && is_digit) begin
            acc_nxt = acc_dig;
          end else if (!end_of_stream && is_semi) begin
            if (32'(pcnt_r) < KEPT_SLOTS) begin
              pv_nxt[pcnt_r[$clog2(KEPT_SLOTS)-1:0]] = acc_r;
            end
            pcnt_nxt = (pcnt_r == 4'hF) ? 4'hF : pcnt_r + 4'd1;
            acc_nxt  = '0;
          end else if (cmd_r == CMD_HEADER) begin
            cmd_nxt = CMD_NONE;
            res_vld = 1'b1;
            if (end_of_stream || data_byte != CH_Q) begin
              mode_nxt = MODE_DONE;
              res_kind = KIND_BAD;
            end else begin
              mode_nxt = MODE_BODY;
              res_kind = KIND_HEADER;
              if (pcnt_r != 4'd0) begin
                opq_nxt = (p2 != 16'd1);
              end
            end
          end else begin
            // List ends: run the pending command, then treat this byte as body
            if (cmd_r == CMD_REPEAT) begin
              rep_nxt = rep_sat;
            end else if (cmd_r == CMD_PALETTE) begin
              if (pcnt_r == 4'd4 && pv_r[1] == 16'd2) begin
                pal_wr.en = 32'(pv_r[0]) < PALETTE_ENTRIES;
              end else if (pcnt_r == 4'd0) begin
                ink_nxt = pal_in_range ? pal_rd_data : 24'd0;
              end
            end
            cmd_nxt  = CMD_NONE;
            mode_nxt = MODE_BODY;
            acc_nxt  = '0;
            do_body  = 1'b1;
          end
        end

        MODE_BODY: begin
          do_body = 1'b1;
        end

        default: begin
        end
      endcase

      if (do_body) begin
        rep_len = (rep_nxt == 13'd0) ? 13'd1 : rep_nxt;
        col_len = 14'(col_r) + 14'(rep_len);
        if (end_of_stream) begin
          mode_nxt = MODE_DONE;
          res_vld  = 1'b1;
          res_kind = KIND_END;
        end else begin
          case (c)
            B_BANG, B_QUOTE, B_HASH: begin
              mode_nxt = MODE_PARAMS;
              cmd_nxt  = (c == B_BANG) ? CMD_REPEAT :
                         (c == B_QUOTE) ? CMD_RASTER : CMD_PALETTE;
              acc_nxt  = '0;
              pcnt_nxt = '0;
            end
            B_DOLLAR: begin
              col_nxt = '0;
            end
            B_MINUS: begin
              if (32'(row_plus6) >= CANVAS_LIMIT) begin
                mode_nxt = MODE_DONE;
                res_vld  = 1'b1;
                res_kind = KIND_END;
              end else begin
                if (13'(col_r) > wid_r) begin
                  wid_nxt = 13'(col_r);
                end
                col_nxt = '0;
                row_nxt = row_plus6[11:0];
                if (row_plus6 > hgt_r) begin
                  hgt_nxt = row_plus6;
                end
              end
            end
            B_CAN, B_SUB, B_ESC, B_FS: begin
              mode_nxt = MODE_DONE;
              res_vld  = 1'b1;
              res_kind = KIND_END;
            end
            default: begin
              if (c inside {[B_SIXEL_FIRST:B_SIXEL_LAST]}) begin
                res_vld = 1'b1;
                if (32'(col_len) >= CANVAS_LIMIT || 32'(row_plus6) >= CANVAS_LIMIT) begin
                  mode_nxt = MODE_DONE;
                  res_kind = KIND_END;
                end else begin
                  col_nxt = col_len[11:0];
                  if (col_len[12:0] > wid_r) begin
                    wid_nxt = col_len[12:0];
                  end
                  rep_nxt  = '0;
                  res_kind = KIND_RUN;
                  res_x    = col_r;
                  res_y    = row_r;
                  res_len  = rep_len[11:0];
                  res_bits = 6'(c - B_SIXEL_FIRST);
                end
              end
            end
          endcase
        end
      end
    end
  end

  // Palette is read at the value the accumulator will hold, so its registered data belongs to acc_r
  assign pal_rd_addr = acc_nxt[PAL_AW-1:0];

  always_comb begin
    res.result_kind       = res_kind;
    res.run_x             = res_x;
    res.band_y            = res_y;
    res.run_length        = res_len;
    res.sixel_bits        = res_bits;
    res.ink_red           = ink_nxt[23:16];
    res.ink_green         = ink_nxt[15:8];
    res.ink_blue          = ink_nxt[7:0];
    res.image_width       = wid_nxt;
    res.image_height      = hgt_nxt;
    res.opaque_background = opq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SEARCH;
      esc_r  <= 1'b0;
      cmd_r  <= CMD_NONE;
      acc_r  <= '0;
      pcnt_r <= '0;
      ink_r  <= '0;
      col_r  <= '0;
      row_r  <= '0;
      wid_r  <= '0;
      hgt_r  <= '0;
      rep_r  <= '0;
      opq_r  <= 1'b1;
    end else begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      cmd_r  <= cmd_nxt;
      acc_r  <= acc_nxt;
      pcnt_r <= pcnt_nxt;
      ink_r  <= ink_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      wid_r  <= wid_nxt;
      hgt_r  <= hgt_nxt;
      rep_r  <= rep_nxt;
      opq_r  <= opq_nxt;
    end
  end

  // Slots are only read back after they were written in the current list
  always_ff @(posedge clk) begin
    pv_r <= pv_nxt;
  end

endmodule

### src/sxd_skid.sv
// Output register with a skid stage so the parser keeps taking bytes under backpressure until the skid stage is full.
module sxd_skid import sxd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  sxd_result_t push_data,
  output logic        ready,
  output logic        out_valid,
  input  logic        out_ready,
  output sxd_result_t out_data
);

  logic        out_v_r, out_v_nxt;
  logic        skid_v_r, skid_v_nxt;
  sxd_result_t out_d_r, out_d_nxt;
  sxd_result_t skid_d_r, skid_d_nxt;

  assign ready     = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_d_nxt  = skid_d_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        out_d_nxt = push_data;
        out_v_nxt = 1'b1;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (push) begin
      skid_d_nxt = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

### src/sixel_stream_decoder.sv
// Sixel stream decoder top level: one byte in per cycle while in_ready is high and zero
// or one result per byte. A result is registered in the output register, or in the skid
// stage while the output is held, before it reaches out_chan.
// in_ready drops only while both the output register and the skid stage hold results.
// Reset (synchronous, active low) clears parser state, not the parameter slots, and the
// palette valid bits at once, so the sixteen default colors read back immediately; no clearing pass.
module sixel_stream_decoder import sxd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  sxd_in_if.sink  in_chan,
  sxd_out_if.source out_chan
);

  logic              in_accept;
  logic              core_ready;
  logic [PAL_AW-1:0] pal_rd_addr;
  logic [23:0]       pal_rd_data;
  sxd_pal_wr_t       pal_wr;
  logic              res_vld;
  sxd_result_t       res;
  sxd_result_t       out_data;

  assign in_chan.ready = core_ready;
  assign in_accept     = in_chan.valid && core_ready;

  sxd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .data_byte     (in_chan.data_byte),
    .end_of_stream (in_chan.end_of_stream),
    .pal_rd_addr   (pal_rd_addr),
    .pal_rd_data   (pal_rd_data),
    .pal_wr        (pal_wr),
    .res_vld       (res_vld),
    .res           (res)
  );

  sxd_palette u_palette (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (pal_wr),
    .rd_addr (pal_rd_addr),
    .rd_data (pal_rd_data)
  );

  sxd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .ready     (core_ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign out_chan.result_kind       = out_data.result_kind;
  assign out_chan.run_x             = out_data.run_x;
  assign out_chan.band_y            = out_data.band_y;
  assign out_chan.run_length        = out_data.run_length;
  assign out_chan.sixel_bits        = out_data.sixel_bits;
  assign out_chan.ink_red           = out_data.ink_red;
  assign out_chan.ink_green         = out_data.ink_green;
  assign out_chan.ink_blue          = out_data.ink_blue;
  assign out_chan.image_width       = out_data.image_width;
  assign out_chan.image_height      = out_data.image_height;
  assign out_chan.opaque_background = out_data.opaque_background;

endmodule

### verif/sixel_stream_decoder_checker.sv
// Channel monitor for the sixel stream decoder: predicts every result and compares it.
module sixel_stream_decoder_checker import sxd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sxd_in_if    in_mon,
  sxd_out_if   out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   bytes_seen,
  output int   results_seen,
  output int   runs_seen
);

  localparam int PARAM_SLOTS = 8;
  localparam int COUNT_CAP   = 15;
  localparam int NUM_CAP     = 65535;
  localparam int REPEAT_CAP  = 8191;
  localparam int PCT_CAP     = 100;
  localparam int SPACE_RGB   = 2;
  localparam int BAND_ROWS   = 6;
  localparam int REPORT_MAX  = 10;

  typedef enum logic [1:0] {SCAN_HUNT, SCAN_PARAMS, SCAN_BODY, SCAN_DONE} scan_e;
  typedef enum logic [2:0] {
    LIST_NONE, LIST_HEADER, LIST_REPEAT, LIST_RASTER, LIST_PALETTE
  } list_e;

  scan_e       scan;
  list_e       list_cmd;
  logic        esc_pending;
  int          num_acc;
  int          arg_count;
  int          args [PARAM_SLOTS];
  logic [23:0] palette [PALETTE_ENTRIES];
  logic [23:0] ink;
  int          col;
  int          row;
  int          width_max;
  int          height_max;
  int          repeat_acc;
  logic        opaque;

  sxd_result_t expected_q [$];
  sxd_result_t want;
  sxd_result_t seen;
  bit          hit;

  function automatic void reset_decoder();
    scan        = SCAN_HUNT;
    list_cmd    = LIST_NONE;
    esc_pending = 1'b0;
    num_acc     = 0;
    arg_count   = 0;
    for (int i = 0; i < PARAM_SLOTS; i++) args[i] = 0;
    for (int i = 0; i < PALETTE_ENTRIES; i++)
      palette[i] = (i < NUM_DEFAULTS) ? DEFAULT_COLORS[i] : 24'h0;
    ink        = 24'h0;
    col        = 0;
    row        = 0;
    width_max  = 0;
    height_max = 0;
    repeat_acc = 0;
    opaque     = 1'b1;
  endfunction

  function automatic sxd_result_t pack_result(input logic [1:0] kind, input int x,
                                              input int y, input int len,
                                              input logic [5:0] bits);
    sxd_result_t r;
    r.result_kind       = kind;
    r.run_x             = 12'(x);
    r.band_y            = 12'(y);
    r.run_length        = 12'(len);
    r.sixel_bits        = bits;
    r.ink_red           = ink[23:16];
    r.ink_green         = ink[15:8];
    r.ink_blue          = ink[7:0];
    r.image_width       = 13'(width_max);
    r.image_height      = 13'(height_max);
    r.opaque_background = opaque;
    return r;
  endfunction

  function automatic sxd_result_t close_image();
    scan = SCAN_DONE;
    return pack_result(KIND_END, 0, 0, 0, 6'd0);
  endfunction

  function automatic void open_list(input list_e cmd);
    num_acc   = 0;
    arg_count = 0;
    for (int i = 0; i < PARAM_SLOTS; i++) args[i] = 0;
    list_cmd = cmd;
    scan     = SCAN_PARAMS;
  endfunction

  function automatic void store_arg();
    if (arg_count < PARAM_SLOTS) args[arg_count] = num_acc;
    if (arg_count < COUNT_CAP) arg_count++;
    num_acc = 0;
  endfunction

  // digits accumulate, ';' closes a parameter; anything else ends the list
  function automatic bit take_param_byte(input logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) begin
      num_acc = num_acc * 10 + int'(b - CH_ZERO);
      if (num_acc > NUM_CAP) num_acc = NUM_CAP;
      return 1'b1;
    end
    if (b == CH_SEMI) begin
      store_arg();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] pct_scale(input int p);
    int q;
    q = (p > PCT_CAP) ? PCT_CAP : p;
    return 8'((q * 255 + 99) / 100);
  endfunction

  function automatic void finish_list();
    int idx;
    int r;
    store_arg();
    if (list_cmd == LIST_REPEAT) begin
      r = (args[0] != 0) ? args[0] : 1;
      repeat_acc += r;
      if (repeat_acc > REPEAT_CAP) repeat_acc = REPEAT_CAP;
    end else if (list_cmd == LIST_PALETTE) begin
      idx = args[0];
      if (arg_count == 5 && args[1] == SPACE_RGB) begin
        if (idx < PALETTE_ENTRIES)
          palette[idx] = {pct_scale(args[2]), pct_scale(args[3]), pct_scale(args[4])};
      end else if (arg_count == 1) begin
        ink = (idx < PALETTE_ENTRIES) ? palette[idx] : 24'h0;
      end
    end
    list_cmd = LIST_NONE;
    scan     = SCAN_BODY;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic eos, output bit got,
                             output sxd_result_t r);
    logic [6:0] c;
    int         len;
    int         x;
    bit         body;
    got  = 1'b0;
    r    = '0;
    body = 1'b0;
    case (scan)
      SCAN_HUNT: begin
        if (eos) begin
          r   = close_image();
          got = 1'b1;
        end else if (esc_pending) begin
          esc_pending = 1'b0;
          if (b == CH_P) open_list(LIST_HEADER);
        end else if (b == CH_DCS) begin
          open_list(LIST_HEADER);
        end else if (b == CH_ESC) begin
          esc_pending = 1'b1;
        end
      end
      SCAN_PARAMS: begin
        if (list_cmd == LIST_HEADER) begin
          if (eos) begin
            scan = SCAN_DONE;
            r    = pack_result(KIND_BAD, 0, 0, 0, 6'd0);
            got  = 1'b1;
          end else if (!take_param_byte(b)) begin
            store_arg();
            list_cmd = LIST_NONE;
            if (b != CH_Q) begin
              scan = SCAN_DONE;
              r    = pack_result(KIND_BAD, 0, 0, 0, 6'd0);
            end else begin
              if (arg_count >= 2) opaque = (args[1] != 1);
              scan = SCAN_BODY;
              r    = pack_result(KIND_HEADER, 0, 0, 0, 6'd0);
            end
            got = 1'b1;
          end
        end else if (eos || !take_param_byte(b)) begin
          // the terminating byte falls through to the body decode
          finish_list();
          body = 1'b1;
        end
      end
      SCAN_BODY: body = 1'b1;
      default: ;
    endcase

    if (body && eos) begin
      r   = close_image();
      got = 1'b1;
    end else if (body) begin
      c = b[6:0];
      case (c)
        B_BANG:   open_list(LIST_REPEAT);
        B_QUOTE:  open_list(LIST_RASTER);
        B_HASH:   open_list(LIST_PALETTE);
        B_DOLLAR: col = 0;
        B_MINUS: begin
          if (row + BAND_ROWS >= CANVAS_LIMIT) begin
            r   = close_image();
            got = 1'b1;
          end else begin
            if (col > width_max) width_max = col;
            col = 0;
            row += BAND_ROWS;
            if (row > height_max) height_max = row;
          end
        end
        B_CAN, B_SUB, B_ESC, B_FS: begin
          r   = close_image();
          got = 1'b1;
        end
        default: begin
          if (c >= B_SIXEL_FIRST && c <= B_SIXEL_LAST) begin
            len = (repeat_acc != 0) ? repeat_acc : 1;
            if (col + len >= CANVAS_LIMIT || row + BAND_ROWS >= CANVAS_LIMIT) begin
              r = close_image();
            end else begin
              x = col;
              col += len;
              if (col > width_max) width_max = col;
              repeat_acc = 0;
              r = pack_result(KIND_RUN, x, row, len, 6'(c - B_SIXEL_FIRST));
            end
            got = 1'b1;
          end
        end
      endcase
    end
  endtask

  function automatic string show(input sxd_result_t r);
    return $sformatf("kind=%0d x=%0d y=%0d len=%0d bits=%h ink=%h%h%h w=%0d h=%0d bg=%0d",
                     r.result_kind, r.run_x, r.band_y, r.run_length, r.sixel_bits,
                     r.ink_red, r.ink_green, r.ink_blue, r.image_width, r.image_height,
                     r.opaque_background);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_decoder();
      expected_q.delete();
      mismatches   = 0;
      outstanding  = 0;
      bytes_seen   = 0;
      results_seen = 0;
      runs_seen    = 0;
    end else begin
      // input side first, so a result leaving in the same cycle as its byte would still find its prediction
      if (in_mon.valid && in_mon.ready) begin
        bytes_seen++;
        decode_byte(in_mon.data_byte, in_mon.end_of_stream, hit, want);
        if (hit) expected_q.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        seen.result_kind       = out_mon.result_kind;
        seen.run_x             = out_mon.run_x;
        seen.band_y            = out_mon.band_y;
        seen.run_length        = out_mon.run_length;
        seen.sixel_bits        = out_mon.sixel_bits;
        seen.ink_red           = out_mon.ink_red;
        seen.ink_green         = out_mon.ink_green;
        seen.ink_blue          = out_mon.ink_blue;
        seen.image_width       = out_mon.image_width;
        seen.image_height      = out_mon.image_height;
        seen.opaque_background = out_mon.opaque_background;
        results_seen++;
        if (seen.result_kind == KIND_RUN) runs_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result transaction: %s", show(seen));
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(seen));
            end
          end
        end
      end
      outstanding = expected_q.size();
    end
  end

endmodule

### verif/sixel_stream_decoder_tb.sv
// Top of the sixel stream decoder testbench: clock, reset, byte stimulus and verdict.
module sixel_stream_decoder_tb import sxd_pkg::*; ();

  localparam int RESET_CYCLES = 8;
  localparam int ITEM_GOAL    = 730;
  localparam int PHASE_LEN    = 250;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPEAT_ROOM  = 3900;
  localparam int BAND_ROWS    = 6;

  logic clk;
  logic rst_n;

  sxd_in_if  in_chan();
  sxd_out_if out_chan();

  int mismatches;
  int outstanding;
  int bytes_seen;
  int results_seen;
  int runs_seen;

  int gap_pct   = 28;
  int stall_pct = 86;
  int sent;
  int cycle_count;
  // coarse cursor view so random runs never hit the canvas edge early
  int col_est;
  int row_est;
  int rep_est;
  int arg_buf [16];
  int arg_n;
  string ending;

  sixel_stream_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sixel_stream_decoder_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .bytes_seen   (bytes_seen),
    .results_seen (results_seen),
    .runs_seen    (runs_seen)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) out_chan.ready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one byte transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (sent < PHASE_LEN) begin
      gap_pct   = 28;
      stall_pct = 86;
    end else if (sent < 2 * PHASE_LEN) begin
      gap_pct   = 86;
      stall_pct = 28;
    end else begin
      gap_pct   = 0;
      stall_pct = 0;
    end
    while ($urandom_range(99) < gap_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid         = 1'b1;
    in_chan.data_byte     = b;
    in_chan.end_of_stream = eos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic top_bit();
    return 1'($urandom_range(1));
  endfunction

  // body codes are seven bits; bit 7 is noise the block must mask off
  task automatic put_code(input logic [6:0] c);
    send_byte({top_bit(), c}, 1'b0);
  endtask

  task automatic send_number(input int n);
    int digits [$];
    int v;
    v = n;
    do begin
      digits.push_front(v % 10);
      v = v / 10;
    end while (v > 0);
    if ($urandom_range(9) == 0) send_byte(CH_ZERO, 1'b0);
    foreach (digits[i]) send_byte(CH_ZERO + 8'(digits[i]), 1'b0);
  endtask

  // negative entries stand for empty parameters
  task automatic send_args();
    for (int i = 0; i < arg_n; i++) begin
      if (i > 0) send_byte(CH_SEMI, 1'b0);
      if (arg_buf[i] >= 0) send_number(arg_buf[i]);
    end
  endtask

  task automatic send_list(input logic [6:0] cmd);
    put_code(cmd);
    send_args();
  endtask

  task automatic send_repeat();
    send_list(B_BANG);
    rep_est += (arg_n == 0 || arg_buf[0] <= 0) ? 1 : arg_buf[0];
  endtask

  task automatic send_run(input logic [7:0] b);
    int len;
    len = (rep_est != 0) ? rep_est : 1;
    if (col_est + len >= CANVAS_LIMIT) begin
      put_code(B_DOLLAR);
      col_est = 0;
    end
    send_byte(b, 1'b0);
    col_est += len;
    rep_est = 0;
  endtask

  task automatic send_linefeed();
    put_code(B_MINUS);
    col_est = 0;
    row_est += BAND_ROWS;
  endtask

  function automatic logic [7:0] random_sixel();
    return {top_bit(), 7'(B_SIXEL_FIRST + $urandom_range(63))};
  endfunction

  function automatic int rand_value(input int hi);
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return -1;
    if (pick < 8) return $urandom_range(99999, 65536);
    return $urandom_range(hi);
  endfunction

  // ignored body byte that cannot extend an open parameter list
  function automatic bit filler_ok(input logic [7:0] b);
    logic [6:0] c;
    c = b[6:0];
    if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI) return 1'b0;
    if (c >= B_SIXEL_FIRST && c <= B_SIXEL_LAST) return 1'b0;
    if (c == B_BANG || c == B_QUOTE || c == B_HASH || c == B_DOLLAR || c == B_MINUS)
      return 1'b0;
    if (c == B_CAN || c == B_SUB || c == B_ESC || c == B_FS) return 1'b0;
    return 1'b1;
  endfunction

  task automatic set_args5(input int a0, input int a1, input int a2, input int a3,
                           input int a4);
    arg_buf[0] = a0;
    arg_buf[1] = a1;
    arg_buf[2] = a2;
    arg_buf[3] = a3;
    arg_buf[4] = a4;
    arg_n      = 5;
  endtask

  task automatic set_arg1(input int a0);
    arg_buf[0] = a0;
    arg_n      = 1;
  endtask

  task automatic random_token();
    int pick;
    int room;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_run(random_sixel());
      // digits outside a list are plain ignored bytes
      if ($urandom_range(9) == 0) send_number($urandom_range(999));
    end else if (pick < 52 && rep_est < REPEAT_ROOM) begin
      room  = REPEAT_ROOM - rep_est;
      arg_n = ($urandom_range(4) == 0) ? 2 : 1;
      if ($urandom_range(9) == 0) arg_n = 0;
      if ($urandom_range(19) == 0) arg_buf[0] = -1;
      else if ($urandom_range(9) == 0) arg_buf[0] = $urandom_range(room);
      else arg_buf[0] = $urandom_range((room < 12) ? room : 12);
      arg_buf[1] = $urandom_range(50);
      send_repeat();
    end else if (pick < 58) begin
      put_code(B_DOLLAR);
      col_est = 0;
    end else if (pick < 64) begin
      if (row_est + 2 * BAND_ROWS < CANVAS_LIMIT) send_linefeed();
    end else if (pick < 74) begin
      set_args5(($urandom_range(7) == 0) ? $urandom_range(299) : $urandom_range(255), 2,
                rand_value(130), rand_value(130), rand_value(130));
      send_list(B_HASH);
    end else if (pick < 82) begin
      set_arg1(($urandom_range(7) == 0) ? rand_value(300) : $urandom_range(20));
      send_list(B_HASH);
    end else if (pick < 86) begin
      arg_n = $urandom_range(9);
      for (int i = 0; i < arg_n; i++) arg_buf[i] = rand_value(120);
      if (arg_n > 1) arg_buf[1] = $urandom_range(3);
      send_list(B_HASH);
    end else if (pick < 90) begin
      arg_n = $urandom_range(6);
      for (int i = 0; i < arg_n; i++) arg_buf[i] = rand_value(999);
      send_list(B_QUOTE);
    end else begin
      repeat ($urandom_range(3, 1)) begin
        do b = 8'($urandom_range(255)); while (!filler_ok(b));
        send_byte(b, 1'b0);
      end
    end
  endtask

  initial begin
    logic [7:0] b;
    in_chan.valid         = 1'b0;
    in_chan.data_byte     = 8'h00;
    in_chan.end_of_stream = 1'b0;
    rst_n                 = 1'b0;
    sent                  = 0;
    col_est               = 0;
    row_est               = 0;
    rep_est               = 0;
    arg_n                 = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // line noise before the introducer
    repeat (8) begin
      do b = 8'($urandom_range(255)); while (b == CH_DCS || b == CH_ESC);
      send_byte(b, 1'b0);
    end
    send_byte(CH_ESC, 1'b0);
    send_byte(8'h41, 1'b0);
    // ESC ESC P: the second ESC is swallowed, so P is only noise
    send_byte(CH_ESC, 1'b0);
    send_byte(CH_ESC, 1'b0);
    send_byte(CH_P, 1'b0);

    if ($urandom_range(1)) begin
      send_byte(CH_DCS, 1'b0);
    end else begin
      send_byte(CH_ESC, 1'b0);
      send_byte(CH_P, 1'b0);
    end
    arg_n = $urandom_range(10);
    for (int i = 0; i < arg_n; i++) arg_buf[i] = rand_value(999);
    if (arg_n >= 2 && $urandom_range(1)) arg_buf[1] = 1;
    send_args();
    send_byte(CH_Q, 1'b0);

    // directed body: palette corners, ink select, repeat, raster, cursor moves
    set_args5(1, 2, 100, 0, 130);
    send_list(B_HASH);
    set_arg1(1);
    send_list(B_HASH);
    send_run(8'h3F);
    set_args5(300, 2, 10, 20, 30);
    send_list(B_HASH);
    set_arg1(300);
    send_list(B_HASH);
    send_run(8'hFE);
    set_args5(2, 1, 50, 50, 50);
    send_list(B_HASH);
    set_args5(-1, 2, -1, -1, -1);
    send_list(B_HASH);
    set_arg1(-1);
    send_list(B_HASH);
    send_run(8'h7E);
    set_arg1(0);
    send_repeat();
    set_arg1(3);
    send_repeat();
    send_run(8'hBF);
    set_args5(1, 1, 100, 100, 0);
    arg_n = 4;
    send_list(B_QUOTE);
    put_code(B_DOLLAR);
    col_est = 0;
    send_linefeed();

    while (sent < ITEM_GOAL) random_token();

    case ($urandom_range(6))
      0: begin
        ending = "end of stream";
        send_byte(8'($urandom_range(255)), 1'b1);
      end
      1: begin
        ending = "CAN";
        put_code(B_CAN);
      end
      2: begin
        ending = "SUB";
        put_code(B_SUB);
      end
      3: begin
        ending = "ESC";
        put_code(B_ESC);
      end
      4: begin
        ending = "FS";
        put_code(B_FS);
      end
      5: begin
        ending = "canvas overflow";
        put_code(B_DOLLAR);
        set_arg1(4095);
        send_list(B_BANG);
        set_arg1($urandom_range(70000, 1));
        send_list(B_BANG);
        send_byte(random_sixel(), 1'b0);
      end
      default: begin
        ending = "end of stream inside a list";
        arg_n = $urandom_range(3, 1);
        for (int i = 0; i < arg_n; i++) arg_buf[i] = $urandom_range(300);
        send_list(B_HASH);
        send_byte(8'($urandom_range(255)), 1'b1);
      end
    endcase
    // after the image is closed nothing may come out, a fresh header included
    send_byte(CH_DCS, 1'b0);
    send_byte(CH_Q, 1'b0);
    repeat (6) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    in_chan.valid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d stream bytes and %0d results checked, %0d of them sixel runs",
             bytes_seen, results_seen, runs_seen);
    $display("three idle profiles run; image closed by %s", ending);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, outstanding);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
